[rtl/core/mlfd_pkg.sv]
package mlfd_pkg;

  localparam int WIN_LEN   = 14;
  localparam int FRAME_LEN = WIN_LEN + 1;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  typedef logic [7:0] byte_t;
  typedef byte_t [FRAME_LEN-1:0] frame_t;
  typedef logic [4:0] digit_t;

  localparam byte_t FRAME_START = 8'h02;
  localparam byte_t SEG_LO_MASK = 8'h0e;
  localparam byte_t SEG_HI_MASK = 8'hf0;

  // symbol codes
  localparam digit_t DIG_BLANK   = 5'd10;
  localparam digit_t DIG_MINUS   = 5'd11;
  localparam digit_t DIG_L       = 5'd12;
  localparam digit_t DIG_C       = 5'd13;
  localparam digit_t DIG_F       = 5'd14;
  localparam digit_t DIG_E       = 5'd15;
  localparam digit_t DIG_N       = 5'd16;
  localparam digit_t DIG_R       = 5'd17;
  localparam digit_t DIG_UNKNOWN = 5'd18;

  localparam logic [2:0] PFX_NONE  = 3'd0;
  localparam logic [2:0] PFX_MEGA  = 3'd1;
  localparam logic [2:0] PFX_KILO  = 3'd2;
  localparam logic [2:0] PFX_MILLI = 3'd3;
  localparam logic [2:0] PFX_MICRO = 3'd4;
  localparam logic [2:0] PFX_NANO  = 3'd5;

  localparam logic [2:0] UNIT_NONE   = 3'd0;
  localparam logic [2:0] UNIT_DEGC   = 3'd1;
  localparam logic [2:0] UNIT_DEGF   = 3'd2;
  localparam logic [2:0] UNIT_OHM    = 3'd3;
  localparam logic [2:0] UNIT_FARAD  = 3'd4;
  localparam logic [2:0] UNIT_HERTZ  = 3'd5;
  localparam logic [2:0] UNIT_VOLT   = 3'd6;
  localparam logic [2:0] UNIT_AMPERE = 3'd7;

  localparam logic [2:0] MODE_NONE  = 3'd0;
  localparam logic [2:0] MODE_DC    = 3'd1;
  localparam logic [2:0] MODE_AC    = 3'd2;
  localparam logic [2:0] MODE_TEMP  = 3'd3;
  localparam logic [2:0] MODE_OHMS  = 3'd4;
  localparam logic [2:0] MODE_CAP   = 3'd5;
  localparam logic [2:0] MODE_FREQ  = 3'd6;
  localparam logic [2:0] MODE_DIODE = 3'd7;

  function automatic digit_t seg_code(input byte_t lo, input byte_t hi);
    byte_t  pat;
    digit_t code;
    pat = (lo & SEG_LO_MASK) | ({hi[3:0], 4'h0} & SEG_HI_MASK);
    unique case (pat)
      8'hbe:   code = 5'd0;
      8'ha0:   code = 5'd1;
      8'hda:   code = 5'd2;
      8'hf8:   code = 5'd3;
      8'he4:   code = 5'd4;
      8'h7c:   code = 5'd5;
      8'h7e:   code = 5'd6;
      8'ha8:   code = 5'd7;
      8'hfe:   code = 5'd8;
      8'hfc:   code = 5'd9;
      8'h00:   code = DIG_BLANK;
      8'h40:   code = DIG_MINUS;
      8'h16:   code = DIG_L;
      8'h1e:   code = DIG_C;
      8'h4e:   code = DIG_F;
      8'h5e:   code = DIG_E;
      8'h62:   code = DIG_N;
      8'h42:   code = DIG_R;
      default: code = DIG_UNKNOWN;
    endcase
    return code;
  endfunction

endpackage

[rtl/core/meter_lcd_frame_decoder.sv]
// channel | signals                       | moves
// input   | in_valid, in_stall, rx_byte   | one serial byte per transaction
// output  | out_valid, out_stall, digit_a..d, decimals, flags, prefix, unit, mode
//         |                               | one decoded frame per transaction
// one byte is taken every cycle while the two-entry frame queue has room
// the edge taking a frame's last byte writes the queue; a pop loads the output
// reset clears the byte window to zeros and empties the queue and output register
// out_stall fills the queue; in_stall rises only when both entries hold frames
module meter_lcd_frame_decoder import mlfd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [4:0] digit_a,
  output logic [4:0] digit_b,
  output logic [4:0] digit_c,
  output logic [4:0] digit_d,
  output logic [1:0] decimals,
  output logic [4:0] flags,
  output logic [2:0] prefix,
  output logic [2:0] unit,
  output logic [2:0] mode
);

  logic   q_full;
  logic   push;
  frame_t push_frame;
  logic   q_valid;
  logic   pop;
  frame_t q_frame;

  mlfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .q_full     (q_full),
    .push       (push),
    .push_frame (push_frame)
  );

  mlfd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_frame (push_frame),
    .full       (q_full),
    .q_valid    (q_valid),
    .pop        (pop),
    .q_frame    (q_frame)
  );

  mlfd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_frame   (q_frame),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .digit_a   (digit_a),
    .digit_b   (digit_b),
    .digit_c   (digit_c),
    .digit_d   (digit_d),
    .decimals  (decimals),
    .flags     (flags),
    .prefix    (prefix),
    .unit      (unit),
    .mode      (mode)
  );

endmodule

[rtl/core/mlfd_front.sv]
module mlfd_front import mlfd_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_stall,
  input  byte_t  rx_byte,
  input  logic   q_full,
  output logic   push,
  output frame_t push_frame
);

  byte_t  window [WIN_LEN];
  logic   accept;
  logic   frame_ok;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    for (int i = 0; i < WIN_LEN; i++) begin
      push_frame[i] = window[i];
    end
    push_frame[WIN_LEN] = rx_byte;
  end

  // start byte then tags 1..14 in the high nibbles
  always_comb begin
    frame_ok = (push_frame[0] == FRAME_START);
    for (int i = 1; i < FRAME_LEN; i++) begin
      if (push_frame[i][7:4] != 4'(i)) begin
        frame_ok = 1'b0;
      end
    end
  end

  assign push = accept && frame_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WIN_LEN; i++) begin
        window[i] <= '0;
      end
    end else if (accept) begin
      for (int i = 0; i < WIN_LEN - 1; i++) begin
        window[i] <= window[i+1];
      end
      window[WIN_LEN-1] <= rx_byte;
    end
  end

endmodule

[rtl/core/mlfd_queue.sv]
module mlfd_queue import mlfd_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  frame_t push_frame,
  output logic   full,
  output logic   q_valid,
  input  logic   pop,
  output frame_t q_frame
);

  frame_t               mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   cnt;

  assign full    = (cnt == Q_CNT_W'(Q_DEPTH));
  assign q_valid = (cnt != '0);
  assign q_frame = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= Q_CNT_W'(Q_DEPTH))
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("pop from empty queue");

  a_cnt_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> cnt == $past(cnt) + 1'b1)
    else $error("count missed a push");
`endif

endmodule

[rtl/core/mlfd_back.sv]
module mlfd_back import mlfd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  frame_t     q_frame,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output digit_t     digit_a,
  output digit_t     digit_b,
  output digit_t     digit_c,
  output digit_t     digit_d,
  output logic [1:0] decimals,
  output logic [4:0] flags,
  output logic [2:0] prefix,
  output logic [2:0] unit,
  output logic [2:0] mode
);

  digit_t     d0, d1, d2, d3;
  logic       temp, dc, ac, over, numeric;
  logic [1:0] point;
  logic [1:0] dec_n;
  logic [4:0] flags_n;
  logic [2:0] prefix_n, unit_n, mode_n;

  assign pop = q_valid && (!out_valid || !out_stall);

  always_comb begin
    d0 = seg_code(q_frame[3], q_frame[4]);
    d1 = seg_code(q_frame[5], q_frame[6]);
    d2 = seg_code(q_frame[7], q_frame[8]);
    d3 = seg_code(q_frame[9], q_frame[10]);

    temp = (d3 == DIG_C) || (d3 == DIG_F);

    // leftmost point wins over the ones to its right
    priority if (q_frame[5][0]) begin
      point = 2'd3;
    end else if (q_frame[7][0]) begin
      point = 2'd2;
    end else if (q_frame[9][0]) begin
      point = 2'd1;
    end else begin
      point = 2'd0;
    end
    if (point == 2'd0) begin
      dec_n = 2'd0;
    end else if (temp) begin
      dec_n = point - 2'd1;
    end else begin
      dec_n = point;
    end

    over    = (d1 == 5'd0) && (d2 == DIG_L);
    numeric = !over && (d0 <= DIG_MINUS) && (d1 <= DIG_MINUS) && (d2 <= DIG_MINUS)
              && (temp || (d3 <= DIG_MINUS));

    flags_n = {q_frame[1][3], q_frame[11][3], numeric, over, q_frame[3][0]};

    priority if (q_frame[11][1]) begin
      prefix_n = PFX_MEGA;
    end else if (q_frame[11][0]) begin
      prefix_n = PFX_KILO;
    end else if (q_frame[13][0]) begin
      prefix_n = PFX_MILLI;
    end else if (q_frame[13][1]) begin
      prefix_n = PFX_MICRO;
    end else if (q_frame[12][0]) begin
      prefix_n = PFX_NANO;
    end else begin
      prefix_n = PFX_NONE;
    end

    dc = q_frame[1][2];
    ac = q_frame[1][1];
    mode_n = dc ? MODE_DC : (ac ? MODE_AC : MODE_NONE);
    unit_n = UNIT_NONE;
    priority if (temp) begin
      unit_n   = (d3 == DIG_C) ? UNIT_DEGC : UNIT_DEGF;
      mode_n   = MODE_TEMP;
      prefix_n = PFX_NONE;
    end else if (q_frame[12][2]) begin
      unit_n = UNIT_OHM;
      mode_n = MODE_OHMS;
    end else if (q_frame[13][2]) begin
      unit_n = UNIT_FARAD;
      mode_n = MODE_CAP;
    end else if (q_frame[12][1]) begin
      unit_n = UNIT_HERTZ;
      mode_n = MODE_FREQ;
    end else if (q_frame[14][2]) begin
      unit_n = UNIT_VOLT;
      if (!dc && !ac) begin
        mode_n = MODE_DIODE;
      end
    end else if (q_frame[14][1]) begin
      unit_n = UNIT_AMPERE;
    end else begin
      unit_n = UNIT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      digit_a  <= d0;
      digit_b  <= d1;
      digit_c  <= d2;
      digit_d  <= d3;
      decimals <= dec_n;
      flags    <= flags_n;
      prefix   <= prefix_n;
      unit     <= unit_n;
      mode     <= mode_n;
    end
  end

endmodule
